// ===== rtl/dpo_pkg.sv =====
// Shared types, constants and microcode ROM for the daily permutation order block.
package dpo_pkg;

    // Element count of the permuted order; 2 .. 16.
    localparam int ORDER_LENGTH = 11;
    localparam int IDX_W        = $clog2(ORDER_LENGTH);
    localparam int MEM_DEPTH    = 2 ** IDX_W;
    localparam int NIB_W        = 4;
    localparam int FULL_W       = NIB_W * ORDER_LENGTH;
    localparam int ORDER_W      = 44;
    localparam int TS_W         = 32;
    localparam int DAY_W        = 16;
    localparam int LEFT_W       = 15;
    localparam int PC_W         = 5;

    // Day divide: 86400 = 675 * 2^7. Drop the low 7 bits, then multiply by a
    // rounded-up reciprocal of 675; exact for every magnitude up to 2^31.
    localparam int SECONDS_PER_DAY = 60 * 60 * 24;
    localparam int DAY_SHIFT       = 7;
    localparam int DAY_ODD         = SECONDS_PER_DAY >> DAY_SHIFT;
    localparam int RECIP_W         = TS_W - DAY_SHIFT;
    localparam int RECIP_SHIFT     = 34;
    localparam int PROD_W          = 2 * RECIP_W;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [TS_W-1:0]          t_ts;
    typedef logic signed [DAY_W-1:0]  t_day;
    typedef logic [ORDER_W-1:0]       t_order;
    typedef logic [FULL_W-1:0]        t_full;
    typedef logic [PC_W-1:0]          t_pc;

    localparam t_ts                EPOCH_RESET = 32'h5725_4700;
    localparam logic [RECIP_W-1:0] DAY_RECIP   =
        RECIP_W'(((longint'(1) << RECIP_SHIFT) + DAY_ODD - 1) / DAY_ODD);
    localparam t_idx               IDX_LAST    = IDX_W'(ORDER_LENGTH - 1);

    // Branch conditions
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DAY_HIT,
        COND_I_NOT_LAST,
        COND_LEFT_ZERO,
        COND_RD_LT_X,
        COND_I_NONZERO,
        COND_RD_LE_Y,
        COND_I_GE_J,
        COND_OUT_BUSY
    } t_cond;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_DIV_LOAD,
        DP_DIV_STEP,
        DP_DAY_SET,
        DP_LEFT_LOAD,
        DP_LEFT_DEC,
        DP_ORD_SHIFT,
        DP_CACHE,
        DP_OUT_LOAD
    } t_dp;

    typedef enum logic [2:0] {I_HOLD, I_ZERO, I_LAST, I_INC, I_DEC, I_FROM_P} t_iop;
    typedef enum logic [1:0] {J_HOLD, J_LAST, J_DEC} t_jop;
    typedef enum logic [1:0] {P_HOLD, P_ZERO, P_I_INC} t_pop;

    typedef enum logic [2:0] {
        RD_NONE, RD_ZERO, RD_LAST, RD_I, RD_I_DEC, RD_I_INC, RD_J, RD_J_DEC
    } t_rdop;

    typedef enum logic [2:0] {
        WR_NONE, WR_I_IDENT, WR_PDEC_X, WR_JINC_Y, WR_I_RDATA, WR_J_X
    } t_wrop;

    typedef struct packed {
        t_cond cond;
        t_pc   target;
        t_dp   dp;
        t_iop  i_op;
        t_jop  j_op;
        t_pop  p_op;
        t_rdop rd_op;
        logic  x_ld;
        logic  y_ld;
        t_wrop wr_op;
    } t_uword;

    // Program addresses
    localparam t_pc PC_IDLE  = 5'd0;
    localparam t_pc PC_DIV   = 5'd1;
    localparam t_pc PC_SIGN  = 5'd2;
    localparam t_pc PC_CHECK = 5'd3;
    localparam t_pc PC_INIT  = 5'd4;
    localparam t_pc PC_TOP   = 5'd5;
    localparam t_pc PC_PV0   = 5'd6;
    localparam t_pc PC_PV1   = 5'd7;
    localparam t_pc PC_PV2   = 5'd8;
    localparam t_pc PC_REV0  = 5'd9;
    localparam t_pc PC_REV1  = 5'd10;
    localparam t_pc PC_REV2  = 5'd11;
    localparam t_pc PC_REV3  = 5'd12;
    localparam t_pc PC_REV4  = 5'd13;
    localparam t_pc PC_NEXT  = 5'd14;
    localparam t_pc PC_SUC0  = 5'd15;
    localparam t_pc PC_SUC1  = 5'd16;
    localparam t_pc PC_SWP0  = 5'd17;
    localparam t_pc PC_SWP1  = 5'd18;
    localparam t_pc PC_CPY0  = 5'd19;
    localparam t_pc PC_CPY1  = 5'd20;
    localparam t_pc PC_CACHE = 5'd21;
    localparam t_pc PC_OUT   = 5'd22;
    localparam t_pc PC_RET   = 5'd23;

    localparam t_uword UW_NOP = '{
        cond: COND_NEVER, target: PC_IDLE, dp: DP_NONE, i_op: I_HOLD, j_op: J_HOLD,
        p_op: P_HOLD, rd_op: RD_NONE, x_ld: 1'b0, y_ld: 1'b0, wr_op: WR_NONE
    };

    function automatic t_full identity_order();
        t_full p;
        p = '0;
        for (int k = 0; k < ORDER_LENGTH; k++) begin
            p[NIB_W*k +: NIB_W] = NIB_W'(k);
        end
        return p;
    endfunction

    // Microcode ROM: a taken condition jumps to target, else fall through.
    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        w = UW_NOP;
        case (pc)
            PC_IDLE: begin
                w.dp = DP_DIV_LOAD; w.cond = COND_NO_INPUT; w.target = PC_IDLE;
            end
            PC_DIV: begin
                w.dp = DP_DIV_STEP;
            end
            PC_SIGN: begin
                w.dp = DP_DAY_SET;
            end
            PC_CHECK: begin
                w.dp = DP_LEFT_LOAD; w.i_op = I_ZERO;
                w.cond = COND_DAY_HIT; w.target = PC_OUT;
            end
            PC_INIT: begin
                w.wr_op = WR_I_IDENT; w.i_op = I_INC;
                w.cond = COND_I_NOT_LAST; w.target = PC_INIT;
            end
            PC_TOP: begin
                w.i_op = I_LAST; w.rd_op = RD_LAST;
                w.cond = COND_LEFT_ZERO; w.target = PC_CPY0;
            end
            PC_PV0: begin
                w.x_ld = 1'b1; w.rd_op = RD_I_DEC;
            end
            PC_PV1: begin
                w.x_ld = 1'b1; w.y_ld = 1'b1; w.i_op = I_DEC;
                w.cond = COND_RD_LT_X; w.target = PC_SUC0;
            end
            PC_PV2: begin
                w.p_op = P_ZERO; w.rd_op = RD_I_DEC;
                w.cond = COND_I_NONZERO; w.target = PC_PV1;
            end
            PC_REV0: begin
                w.i_op = I_FROM_P; w.j_op = J_LAST;
            end
            PC_REV1: begin
                w.rd_op = RD_I; w.cond = COND_I_GE_J; w.target = PC_NEXT;
            end
            PC_REV2: begin
                w.x_ld = 1'b1; w.rd_op = RD_J;
            end
            PC_REV3: begin
                w.wr_op = WR_I_RDATA;
            end
            PC_REV4: begin
                w.wr_op = WR_J_X; w.i_op = I_INC; w.j_op = J_DEC;
                w.cond = COND_ALWAYS; w.target = PC_REV1;
            end
            PC_NEXT: begin
                w.dp = DP_LEFT_DEC; w.cond = COND_ALWAYS; w.target = PC_TOP;
            end
            PC_SUC0: begin
                w.p_op = P_I_INC; w.j_op = J_LAST; w.rd_op = RD_LAST;
            end
            PC_SUC1: begin
                w.x_ld = 1'b1; w.j_op = J_DEC; w.rd_op = RD_J_DEC;
                w.cond = COND_RD_LE_Y; w.target = PC_SUC1;
            end
            PC_SWP0: begin
                w.wr_op = WR_PDEC_X;
            end
            PC_SWP1: begin
                w.wr_op = WR_JINC_Y; w.cond = COND_ALWAYS; w.target = PC_REV0;
            end
            PC_CPY0: begin
                w.i_op = I_ZERO; w.rd_op = RD_ZERO;
            end
            PC_CPY1: begin
                w.dp = DP_ORD_SHIFT; w.rd_op = RD_I_INC; w.i_op = I_INC;
                w.cond = COND_I_NOT_LAST; w.target = PC_CPY1;
            end
            PC_CACHE: begin
                w.dp = DP_CACHE;
            end
            PC_OUT: begin
                w.dp = DP_OUT_LOAD; w.cond = COND_OUT_BUSY; w.target = PC_OUT;
            end
            PC_RET: begin
                w.cond = COND_ALWAYS; w.target = PC_IDLE;
            end
            default: begin
                w.cond = COND_ALWAYS; w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/daily_permutation_order.sv =====
// Daily permutation order: microcoded day-index divider and lexicographic stepper.
// A repeated day index runs magnitude load, reciprocal multiply by 1/86400, sign fix,
//   cache check and an output load that waits while the held result is stalled.
// A new day index adds an identity fill, one permutation step per day, a copy into the
//   cached order and a cache update; the element memory sets the cost of each step.
// The next transaction is taken only in idle, after the result loads and a return step.
// Reset (synchronous, active low): epoch back to its default, cache holds day -1 / identity.
module daily_permutation_order (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  dpo_pkg::t_ts            i_cfg_data,
    // timestamp input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  dpo_pkg::t_ts            i_timestamp,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output dpo_pkg::t_order         o_order_packed,
    output dpo_pkg::t_day           o_day_index
);
    import dpo_pkg::*;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    t_pc    r_pc, n_pc;
    t_uword uw;
    logic   take;

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    t_ts               r_epoch;
    t_ts               r_num;        // magnitude, becomes quotient
    logic              r_neg;
    t_day              r_day;
    t_day              r_cached_day;
    logic [LEFT_W-1:0] r_left;       // permutation steps still to apply
    t_full             r_ord;        // cached order, filled by shifting
    t_idx              r_i, r_j, r_p;
    t_idx              r_x, r_y;
    t_idx              r_rdata;
    t_idx              r_mem [MEM_DEPTH];
    logic              r_out_valid;
    t_order            r_out_order;
    t_day              r_out_day;

    // divider and sign handling
    t_ts               diff, mag;
    logic [PROD_W-1:0] prod;
    logic [DAY_W-1:0]  quo;

    // memory port controls
    logic rd_en, wr_en;
    t_idx rd_addr, wr_addr, wr_data;
    logic out_busy;

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_pc != PC_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_order_packed = r_out_order;
    assign o_day_index    = r_out_day;

    assign out_busy = r_out_valid && i_out_stall;

    always_comb begin
        uw = ucode_rom(r_pc);
    end

    // Branch condition select
    always_comb begin
        case (uw.cond)
            COND_NEVER:      take = 1'b0;
            COND_ALWAYS:     take = 1'b1;
            COND_NO_INPUT:   take = !i_in_valid;
            COND_DAY_HIT:    take = (r_day == r_cached_day);
            COND_I_NOT_LAST: take = (r_i != IDX_LAST);
            COND_LEFT_ZERO:  take = (r_left == '0);
            COND_RD_LT_X:    take = (r_rdata < r_x);
            COND_I_NONZERO:  take = (r_i != '0);
            COND_RD_LE_Y:    take = (r_rdata <= r_y);
            COND_I_GE_J:     take = (r_i >= r_j);
            COND_OUT_BUSY:   take = out_busy;
            default:         take = 1'b0;
        endcase
    end

    always_comb begin
        n_pc = take ? uw.target : r_pc + PC_W'(1);
    end

    // Divider front end: signed difference, magnitude, reciprocal multiply
    always_comb begin
        diff = i_timestamp - r_epoch;
        mag  = diff[TS_W-1] ? (~diff + TS_W'(1)) : diff;
        prod = PROD_W'(r_num[TS_W-1:DAY_SHIFT]) * PROD_W'(DAY_RECIP);
        quo  = r_num[DAY_W-1:0];
    end

    // Element memory addressing
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = '0;
        case (uw.rd_op)
            RD_NONE:  rd_en   = 1'b0;
            RD_ZERO:  rd_addr = '0;
            RD_LAST:  rd_addr = IDX_LAST;
            RD_I:     rd_addr = r_i;
            RD_I_DEC: rd_addr = r_i - IDX_W'(1);
            RD_I_INC: rd_addr = r_i + IDX_W'(1);
            RD_J:     rd_addr = r_j;
            RD_J_DEC: rd_addr = r_j - IDX_W'(1);
            default:  rd_en   = 1'b0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_i;
        wr_data = r_i;
        case (uw.wr_op)
            WR_NONE:    wr_en = 1'b0;
            WR_I_IDENT: begin wr_addr = r_i;              wr_data = r_i;     end
            WR_PDEC_X:  begin wr_addr = r_p - IDX_W'(1);  wr_data = r_x;     end
            WR_JINC_Y:  begin wr_addr = r_j + IDX_W'(1);  wr_data = r_y;     end
            WR_I_RDATA: begin wr_addr = r_i;              wr_data = r_rdata; end
            WR_J_X:     begin wr_addr = r_j;              wr_data = r_x;     end
            default:    wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Control and cached state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= PC_IDLE;
            r_out_valid  <= 1'b0;
            r_epoch      <= EPOCH_RESET;
            r_cached_day <= -DAY_W'(1);
            r_ord        <= identity_order();
        end else begin
            r_pc <= n_pc;
            if (i_cfg_valid) begin
                r_epoch <= i_cfg_data;
            end
            if (uw.dp == DP_ORD_SHIFT) begin
                r_ord <= {NIB_W'(r_rdata), r_ord[FULL_W-1:NIB_W]};
            end
            if (uw.dp == DP_CACHE) begin
                r_cached_day <= r_day;
            end
            if (uw.dp == DP_OUT_LOAD && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath payload
    always_ff @(posedge i_clk) begin
        case (uw.dp)
            DP_DIV_LOAD: begin
                r_neg <= diff[TS_W-1];
                r_num <= mag;
            end
            DP_DIV_STEP:  r_num  <= TS_W'(prod[PROD_W-1:RECIP_SHIFT]);
            DP_DAY_SET:   r_day  <= r_neg ? $signed(~quo + DAY_W'(1)) : $signed(quo);
            DP_LEFT_LOAD: r_left <= r_day[DAY_W-1] ? '0 : r_day[LEFT_W-1:0];
            DP_LEFT_DEC:  r_left <= r_left - LEFT_W'(1);
            DP_OUT_LOAD: begin
                if (!out_busy) begin
                    r_out_order <= ORDER_W'(r_ord);
                    r_out_day   <= r_day;
                end
            end
            default: ;
        endcase

        case (uw.i_op)
            I_ZERO:   r_i <= '0;
            I_LAST:   r_i <= IDX_LAST;
            I_INC:    r_i <= r_i + IDX_W'(1);
            I_DEC:    r_i <= r_i - IDX_W'(1);
            I_FROM_P: r_i <= r_p;
            default:  ;
        endcase

        case (uw.j_op)
            J_LAST:  r_j <= IDX_LAST;
            J_DEC:   r_j <= r_j - IDX_W'(1);
            default: ;
        endcase

        case (uw.p_op)
            P_ZERO:  r_p <= '0;
            P_I_INC: r_p <= r_i + IDX_W'(1);
            default: ;
        endcase

        if (uw.x_ld) begin
            r_x <= r_rdata;
        end
        if (uw.y_ld) begin
            r_y <= r_rdata;
        end
    end

endmodule

// ===== bench/dpo_order_checker.sv =====
// Monitor, day/order predictor and result comparison for the daily permutation order block.
`timescale 1ns / 100ps

module dpo_order_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  dpo_pkg::t_ts            i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  dpo_pkg::t_ts            i_timestamp,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  dpo_pkg::t_order         i_order_packed,
    input  dpo_pkg::t_day           i_day_index,
    output int                      o_fail_count,
    output int                      o_pending
);
    import dpo_pkg::*;

    localparam int unsigned DAY_SECONDS = 86400;

    typedef struct packed {
        t_order order;
        t_day   day;
    } t_day_order;

    t_ts        epoch;
    int         cached_day;
    t_order     cached_order;
    t_day_order pending_orders[$];
    int         fails = 0;

    // signed day count, truncated toward zero
    function automatic int day_of_stamp(input t_ts stamp, input t_ts base);
        logic [31:0] diff;
        logic [31:0] mag;
        diff = stamp - base;
        if (diff[31]) begin
            mag = ~diff + 32'd1;
            return -int'(mag / DAY_SECONDS);
        end
        return int'(diff / DAY_SECONDS);
    endfunction

    // identity order advanced 'days' times by next-lexicographic permutation
    function automatic t_order order_after_days(input int days);
        logic [3:0]  seq [ORDER_LENGTH];
        logic [3:0]  held;
        logic [63:0] nibbles;
        int          lo;
        int          hi;
        int          pivot;
        for (int k = 0; k < ORDER_LENGTH; k++) seq[k] = 4'(k);
        for (int d = 0; d < days; d++) begin
            lo = ORDER_LENGTH - 1;
            while (lo > 0 && seq[lo-1] >= seq[lo]) lo--;
            pivot = lo;
            if (pivot > 0) begin
                hi = ORDER_LENGTH - 1;
                while (hi > pivot && seq[hi] <= seq[pivot-1]) hi--;
                held = seq[pivot-1];
                seq[pivot-1] = seq[hi];
                seq[hi] = held;
            end
            lo = pivot;
            hi = ORDER_LENGTH - 1;
            while (lo < hi) begin
                held = seq[lo];
                seq[lo] = seq[hi];
                seq[hi] = held;
                lo++;
                hi--;
            end
        end
        nibbles = '0;
        for (int k = 0; k < ORDER_LENGTH; k++) nibbles[4*k +: 4] = seq[k];
        return t_order'(nibbles);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_day_order fresh;
        t_day_order want;
        int         day;
        if (!i_rst_n) begin
            epoch = EPOCH_RESET;
            cached_day = -1;
            cached_order = order_after_days(0);
            pending_orders.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) epoch = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                day = day_of_stamp(i_timestamp, epoch);
                if (day != cached_day) begin
                    cached_order = order_after_days(day);
                    cached_day = day;
                end
                fresh.order = cached_order;
                fresh.day = t_day'(day);
                pending_orders.push_back(fresh);
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_orders.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, order %h day %0d",
                             $time, i_order_packed, i_day_index);
                end else begin
                    want = pending_orders.pop_front();
                    if (i_order_packed !== want.order) begin
                        fails++;
                        $display("%0t: order_packed expected %h, actual %h",
                                 $time, want.order, i_order_packed);
                    end
                    if (i_day_index !== want.day) begin
                        fails++;
                        $display("%0t: day_index expected %0d, actual %0d",
                                 $time, want.day, i_day_index);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= pending_orders.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Stimulus, handshake idling, watchdog and verdict for the daily permutation order block.
`timescale 1ns / 100ps

module tb_top;
    import dpo_pkg::*;

    localparam t_ts ONE_DAY        = 32'd86400;
    // A cold day near +24855 walks ~25k permutation steps.
    localparam int  WATCHDOG_LIMIT = 6_000_000;
    // Drain time after the last result, well above the hit latency.
    localparam int  TAIL_CYCLES    = 64;

    typedef enum int unsigned {STALL_NONE, STALL_SPARSE, STALL_HOLD, STALL_TOGGLE} t_stall_mode;

    logic     i_clk;
    logic     i_rst_n     = 1'b0;
    logic     i_cfg_valid = 1'b0;
    t_ts      i_cfg_data  = '0;
    logic     i_in_valid  = 1'b0;
    t_ts      i_timestamp = '0;
    logic     i_out_stall = 1'b0;
    logic     o_cfg_ready;
    logic     o_in_stall;
    logic     o_out_valid;
    t_order   o_order_packed;
    t_day     o_day_index;

    int       fail_count;
    int       pending_count;

    // sender burst bookkeeping and the last stamp, for repeat-day items
    int       burst_left = 0;
    t_ts      last_stamp = '0;

    daily_permutation_order dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_timestamp    (i_timestamp),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_order_packed (o_order_packed),
        .o_day_index    (o_day_index)
    );

    dpo_order_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_timestamp    (i_timestamp),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_order_packed (o_order_packed),
        .i_day_index    (o_day_index),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // One timestamp transaction. Bursts of random length, random gaps between them;
    // a quarter of the bursts follow the previous one back to back.
    task automatic send_stamp(input t_ts stamp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_timestamp <= stamp;
        // payload holds until the edge where stall is low
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
    endtask

    // Drop valid and wait until every predicted result has come out. The first
    // edge lets the checker count an item taken at the edge just passed.
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // Epoch write, only issued with the block idle.
    task automatic write_epoch(input t_ts value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Random stamp relative to the current epoch. Mostly small positive days so the
    // stepper stays cheap; full-range negative offsets exercise the signed divide and
    // spread the upper timestamp bits; a few land on the -1/0/+1 day boundaries.
    function automatic t_ts pick_stamp(input t_ts base);
        logic [31:0] diff;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return last_stamp;                  // same day again: cache hit
        else if (pick < 50)
            diff = $urandom_range(0, 60) * ONE_DAY + $urandom_range(0, 86399);
        else if (pick < 63)
            diff = $urandom_range(61, 600) * ONE_DAY + $urandom_range(0, 86399);
        else if (pick < 67)
            diff = $urandom_range(601, 2000) * ONE_DAY + $urandom_range(0, 86399);
        else if (pick < 92)
            diff = {1'b1, 31'($urandom())};
        else
            diff = ($urandom_range(0, 2) - 1) * ONE_DAY + $urandom_range(0, 2) - 1;
        last_stamp = base + diff;
        return last_stamp;
    endfunction

    // Result-side stall: each stretch picks a pattern (free flow, sparse stalls,
    // solid hold, toggle) and a length, independent of the sender.
    always @(posedge i_clk) begin : out_stall_pattern
        t_stall_mode mode;
        int unsigned left;
        if (left == 0) begin
            mode = t_stall_mode'($urandom_range(0, 3));
            left = $urandom_range(4, 40);
        end
        left--;
        case (mode)
            STALL_NONE:   i_out_stall <= 1'b0;
            STALL_SPARSE: i_out_stall <= ($urandom_range(0, 2) == 0);
            STALL_HOLD:   i_out_stall <= 1'b1;
            default:      i_out_stall <= ~i_out_stall;
        endcase
    end

    // Watchdog: any transaction on any channel restarts the count.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        t_ts stamps[$];
        t_ts epoch_now;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset epoch. First item is day -1, which matches the empty cache and
        // must give the identity. Then truncation toward zero on both sides of
        // the epoch, a repeated day, a step back to an earlier day, both ends of
        // the timestamp range and the most negative day.
        stamps = '{
            EPOCH_RESET - ONE_DAY,
            EPOCH_RESET - 32'd86399,
            EPOCH_RESET,
            EPOCH_RESET + 32'd86399,
            EPOCH_RESET + ONE_DAY,
            EPOCH_RESET + 5 * ONE_DAY + 32'd7,
            EPOCH_RESET + 5 * ONE_DAY + 32'd86000,
            EPOCH_RESET + 3 * ONE_DAY,
            32'h0000_0000,
            32'hFFFF_FFFF,
            EPOCH_RESET + 32'h8000_0000,
            EPOCH_RESET + 720 * ONE_DAY
        };
        foreach (stamps[k]) send_stamp(stamps[k]);

        // Epoch zero: the largest positive day (the longest computation of the
        // run), both encodings of the most negative day, -1 second and -1 day.
        wait_results_done();
        write_epoch(32'h0000_0000);
        stamps = '{
            32'h0000_0000,
            32'h7FFF_FFFF,
            32'h8000_0000,
            32'h8000_0001,
            32'hFFFF_FFFF,
            32'h0000_0000 - ONE_DAY
        };
        foreach (stamps[k]) send_stamp(stamps[k]);

        // All-ones epoch: subtraction wraps for every stamp below the epoch.
        wait_results_done();
        write_epoch(32'hFFFF_FFFF);
        stamps = '{
            32'h0000_0000,
            32'h0001_5180,
            32'h8000_0000,
            32'hFFFF_FFFF,
            32'h0001_517F
        };
        foreach (stamps[k]) send_stamp(stamps[k]);

        // Random phases, one epoch each; the third puts the reset value back.
        for (int ph = 0; ph < 4; ph++) begin
            epoch_now = (ph == 2) ? EPOCH_RESET : t_ts'($urandom());
            wait_results_done();
            write_epoch(epoch_now);
            for (int n = 0; n < 25; n++) send_stamp(pick_stamp(epoch_now));
        end

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== daily_permutation_order.f =====
rtl/dpo_pkg.sv
rtl/daily_permutation_order.sv
bench/dpo_order_checker.sv
bench/tb_top.sv
